### src/dsf_pkg.sv
`timescale 1ns / 1ps

package dsf_pkg;

   // Line store geometry
   localparam int BUFFER_BYTES = 64;
   localparam int PTR_W        = $clog2(BUFFER_BYTES);
   localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(BUFFER_BYTES - 1);

   // Front queue geometry
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   // Character codes
   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NUL     = 8'h00;

   // Classified byte handed from front to back
   typedef struct packed {
      logic [7:0] data;
      logic       is_dollar;
      logic       is_newline;
   } qentry_type;

   // Back-end sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRIME,
      ST_EMIT,
      ST_SEEK
   } state_type;

endpackage

### src/dsf_front.sv
`timescale 1ns / 1ps

module dsf_front import dsf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       q_valid,
   output qentry_type q_entry,
   input  logic       q_pop
);

   qentry_type          entry_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     fill_ff, fill_in;
   logic                push;
   qentry_type          new_entry;

   // stall only on a full queue
   assign req_stall = (fill_ff == (QPTR_W+1)'(QDEPTH));

   // classify; NUL bytes are accepted and dropped
   assign push = req_valid && !req_stall && (req_rx_byte != CH_NUL);
   always_comb begin
      new_entry.data       = req_rx_byte;
      new_entry.is_dollar  = (req_rx_byte == CH_DOLLAR);
      new_entry.is_newline = (req_rx_byte == CH_NEWLINE);
   end

   assign q_valid = (fill_ff != '0);
   assign q_entry = entry_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !q_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && q_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

### src/dsf_back.sv
`timescale 1ns / 1ps

module dsf_back import dsf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  qentry_type q_entry,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);

   // circular line store, head points at the leading '$' when non-empty
   logic [7:0]       mem [BUFFER_BYTES];
   logic [7:0]       rd_data_ff;
   logic [PTR_W-1:0] rd_addr;
   logic             wr_en;
   logic [PTR_W-1:0] wr_addr;

   state_type        state_ff, state_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] nl_ff, nl_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [PTR_W-1:0] left_ff, left_in;
   logic             first_ff, first_in;
   logic             found_ff, found_in;
   logic [PTR_W-1:0] dol_ptr_ff, dol_ptr_in;
   logic [PTR_W-1:0] dol_left_ff, dol_left_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [PTR_W:0]   tail_sum;
   logic [PTR_W-1:0] tail;
   logic [PTR_W-1:0] ptr_next;
   logic             rsp_free;
   logic             room;
   logic [PTR_W-1:0] nl_after_push;
   logic             d_dollar, d_newline;

   // tail = head + count, wrapped
   assign tail_sum = {1'b0, head_ff} + {1'b0, count_ff};
   assign tail = (tail_sum >= (PTR_W+1)'(BUFFER_BYTES))
                 ? PTR_W'(tail_sum - (PTR_W+1)'(BUFFER_BYTES))
                 : tail_sum[PTR_W-1:0];
   assign ptr_next = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + 1'b1;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign room      = (count_ff < LAST_IDX);
   assign d_dollar  = (rd_data_ff == CH_DOLLAR);
   assign d_newline = (rd_data_ff == CH_NEWLINE);

   // newline count after this cycle's append; an empty store keeps only '$'
   always_comb begin
      nl_after_push = nl_ff;
      if (room && count_ff != '0 && q_entry.is_newline) begin
         nl_after_push = nl_ff + 1'b1;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid && nl_after_push != '0) begin
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: state_in = ST_EMIT;
         ST_EMIT: begin
            if (rsp_free && d_newline) begin
               if (found_ff || left_ff == PTR_W'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_SEEK;
               end
            end
         end
         ST_SEEK: begin
            if (d_dollar || left_ff == PTR_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and handshake outputs
   always_comb begin
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = tail;
      rd_addr      = ptr_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      nl_in        = nl_ff;
      ptr_in       = ptr_ff;
      left_in      = left_ff;
      first_in     = first_ff;
      found_in     = found_ff;
      dol_ptr_in   = dol_ptr_ff;
      dol_left_in  = dol_left_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               // append; a non-'$' into an empty store is discarded by resync
               if (room && (count_ff != '0 || q_entry.is_dollar)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               nl_in = nl_after_push;
            end
         end
         ST_PRIME: begin
            rd_addr     = head_ff;
            ptr_in      = head_ff;
            left_in     = count_ff;
            first_in    = 1'b1;
            found_in    = 1'b0;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = rd_data_ff;
               rsp_last_in  = d_newline;
               first_in     = 1'b0;
               if (d_newline) begin
                  if (found_ff) begin
                     // resume at the first '$' inside the sentence
                     head_in  = dol_ptr_ff;
                     count_in = dol_left_ff;
                  end else begin
                     nl_in = nl_ff - 1'b1;
                     if (left_ff == PTR_W'(1)) begin
                        head_in  = '0;
                        count_in = '0;
                     end else begin
                        ptr_in  = ptr_next;
                        left_in = left_ff - 1'b1;
                        rd_addr = ptr_next;
                     end
                  end
               end else begin
                  // leading '$' is replaced, so only later ones count
                  if (!first_ff && d_dollar && !found_ff) begin
                     found_in    = 1'b1;
                     dol_ptr_in  = ptr_ff;
                     dol_left_in = left_ff;
                  end
                  ptr_in  = ptr_next;
                  left_in = left_ff - 1'b1;
                  rd_addr = ptr_next;
               end
            end
         end
         ST_SEEK: begin
            // discard up to the next '$'
            if (d_dollar) begin
               head_in  = ptr_ff;
               count_in = left_ff;
            end else begin
               if (d_newline) begin
                  nl_in = nl_ff - 1'b1;
               end
               if (left_ff == PTR_W'(1)) begin
                  head_in  = '0;
                  count_in = '0;
               end else begin
                  ptr_in  = ptr_next;
                  left_in = left_ff - 1'b1;
                  rd_addr = ptr_next;
               end
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         nl_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         nl_ff        <= nl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      left_ff     <= left_in;
      first_ff    <= first_in;
      found_ff    <= found_in;
      dol_ptr_ff  <= dol_ptr_in;
      dol_left_ff <= dol_left_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   // line store: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= q_entry.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_last = rsp_last_ff;

   // newlines held never exceed bytes held
   a_nl_le_count: assert property (@(posedge clock) disable iff (reset)
      nl_ff <= count_ff)
      else $error("newline count exceeds fill count");

   // a scan starts only with a complete sentence held
   a_prime_has_nl: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PRIME |-> nl_ff != '0 && count_ff != '0)
      else $error("scan started without a held newline");

   // every sentence opens with '$'
   a_first_dollar: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && first_ff && rsp_free |=> rsp_byte_ff == CH_DOLLAR)
      else $error("sentence does not start with dollar");

   // results come only out of the emit state
   a_emit_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EMIT)
      else $error("result produced outside emit state");

endmodule

### src/dollar_sentence_framer_unit.sv
`timescale 1ns / 1ps

// Sentence framer for a received character stream.
// req_ channel: one received byte per transaction (req_rx_byte). NUL bytes
//   are accepted and ignored. req_stall rises only when the 4-entry input
//   queue is full.
// rsp_ channel: one sentence character per transaction (rsp_out_byte),
//   rsp_out_last marks the newline closing the sentence. A sentence runs
//   from its '$' through the first newline; at most one is sent per byte.
// Path: a byte that completes a sentence goes through the input queue, the
//   idle, prime and emit states and the output register to show its '$'.
// Throughput: a byte that emits nothing needs only the idle state; one that
//   emits holds off the next byte until the scan ends, set by the single
//   read port of the line store scanned one entry per cycle unless stalled.
// Receiver stall: the output register holds its transaction and the emit scan
//   pauses; the input queue keeps taking bytes until it fills.
// Reset (synchronous): empties the queue and the line store and drops any
//   pending result.
module dollar_sentence_framer_unit import dsf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);

   logic       q_valid;
   logic       q_pop;
   qentry_type q_entry;

   // accept and classify
   dsf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .q_valid     (q_valid),
      .q_entry     (q_entry),
      .q_pop       (q_pop)
   );

   // line store and sentence extraction
   dsf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_entry      (q_entry),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule

### dv/dollar_sentence_framer_unit_tb.sv
`timescale 1ns / 1ps

module dollar_sentence_framer_unit_tb;
   import dsf_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 400;
   localparam int RANDOM_ITEMS   = 100;
   localparam int DRAIN_CYCLES   = 80;

   // One character of an extracted sentence
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } sentence_char_type;

   // Line store shadow and queue of sentence characters still owed by the block
   class sentence_scoreboard_type;
      logic [7:0]        line_store [BUFFER_BYTES];
      int                fill;
      sentence_char_type pending [$];
      int                errors;

      function new();
         clear_store();
         errors = 0;
      endfunction

      function void clear_store();
         foreach (line_store[i]) line_store[i] = CH_NUL;
         fill = 0;
      endfunction

      // Drop everything ahead of the first '$'; no '$' empties the store
      function void align_to_dollar();
         int p;
         int keep;
         p = 0;
         while (p < fill && line_store[p] != CH_DOLLAR) p++;
         if (p >= fill) begin
            clear_store();
            return;
         end
         if (p > 0) begin
            keep = fill - p;
            for (int i = 0; i < BUFFER_BYTES; i++) begin
               if (i < keep) line_store[i] = line_store[i + p];
               else line_store[i] = CH_NUL;
            end
            fill = keep;
         end
      endfunction

      function bit holds_newline();
         for (int i = 0; i < fill; i++)
            if (line_store[i] == CH_NEWLINE) return 1'b1;
         return 1'b0;
      endfunction

      // Accepted byte: append, realign, and queue any completed sentence
      function void note_byte(input logic [7:0] b);
         int e;
         sentence_char_type c;
         if (b == CH_NUL) return;
         if (fill < BUFFER_BYTES - 1) begin
            line_store[fill] = b;
            fill++;
         end
         align_to_dollar();
         if (fill == 0 || line_store[0] != CH_DOLLAR) return;
         e = 0;
         while (e < fill && line_store[e] != CH_NEWLINE) e++;
         if (e >= fill) return;
         for (int k = 0; k <= e; k++) begin
            c.ch   = line_store[k];
            c.last = (k == e);
            pending.push_back(c);
         end
         line_store[0] = CH_ZERO;
         align_to_dollar();
      endfunction

      // Accepted result against the oldest owed character
      function void check_char(input logic [7:0] ch, input logic last);
         sentence_char_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected sentence char, expected none, got byte %h last %b",
                     $time, ch, last);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (ch !== want.ch) begin
            $display("%0t: out_byte mismatch, expected %h, got %h", $time, want.ch, ch);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0t: out_last mismatch, expected %b, got %b", $time, want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;

   sentence_scoreboard_type sb = new();
   int  burst_left    = 0;
   int  random_items  = 0;
   int  quiet_cycles  = 0;
   bit  hold_request  = 1'b0;

   dollar_sentence_framer_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

   always #10 clock = ~clock;

   // Offer one byte, pacing the sender in bursts with gaps between them
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      sb.note_byte(b);
      @(negedge clock);
   endtask

   // Random traffic: a store about to fill with no newline would lock up for
   // good, so a newline goes in its place
   task automatic send_guarded(input logic [7:0] b);
      logic [7:0] v;
      v = b;
      if (v != CH_NUL && sb.fill >= BUFFER_BYTES - 2 && !sb.holds_newline())
         v = CH_NEWLINE;
      send_byte(v);
      if (v != CH_NUL) random_items++;
   endtask

   function automatic logic [7:0] text_char();
      if ($urandom_range(0, 9) == 0) return CH_DOLLAR;
      return 8'($urandom_range(8'h20, 8'h7E));
   endfunction

   task automatic send_sentence(input bit closed);
      int len;
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 61) : $urandom_range(0, 12);
      send_guarded(CH_DOLLAR);
      repeat (len) send_guarded(text_char());
      if (closed) send_guarded(CH_NEWLINE);
   endtask

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_char(rsp_out_byte, rsp_out_last);
   end

   // Watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Receiver stall pattern, with one long hold-off on request
   initial begin : receiver_pattern
      int mode;
      int span;
      @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(8, 64);
         repeat (span) begin
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= 1'($urandom_range(0, 1));
               2: rsp_stall <= ($urandom_range(0, 9) < 8);
               default: rsp_stall <= ($urandom_range(0, 9) == 0);
            endcase
            @(negedge clock);
         end
      end
   end

   initial begin : stimulus
      int kind;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: ignored NUL, stray newline, garbage with no '$'
      send_byte(CH_NUL);
      send_byte(CH_NEWLINE);
      send_byte("X");
      send_byte("Y");
      // Shortest sentence
      send_byte(CH_DOLLAR);
      send_byte(CH_NEWLINE);
      // Garbage ahead of a sentence is dropped
      send_byte("a");
      send_byte("b");
      send_byte(CH_DOLLAR);
      send_byte("A");
      send_byte(CH_NEWLINE);
      // Inner '$': second sentence stays held and comes out on the next byte
      send_byte(CH_DOLLAR);
      send_byte("1");
      send_byte(CH_DOLLAR);
      send_byte("2");
      send_byte(CH_NEWLINE);
      send_byte("Z");
      // NUL inside a sentence and extreme byte values
      send_byte(CH_DOLLAR);
      send_byte(CH_NUL);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(8'h01);
      send_byte(CH_NEWLINE);
      // Longest sentence the store can hold
      send_byte(CH_DOLLAR);
      for (int k = 0; k < BUFFER_BYTES - 3; k++) send_byte(8'("A" + k % 26));
      send_byte(CH_NEWLINE);

      // Random: mostly well-formed sentences, plus noise and broken ones
      hold_request = 1'b1;
      while (random_items < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 15);
         if (kind <= 9) begin
            send_sentence(1'b1);
         end else if (kind <= 11) begin
            repeat ($urandom_range(1, 6)) send_guarded(8'($urandom_range(0, 255)));
         end else if (kind == 12) begin
            send_sentence(1'b0);
         end else if (kind == 13) begin
            repeat ($urandom_range(1, 3)) send_guarded(CH_NUL);
         end else if (kind == 14) begin
            repeat ($urandom_range(1, 5)) send_guarded(8'($urandom_range(8'h20, 8'h7E)));
            send_sentence(1'b1);
         end else begin
            send_guarded(CH_NEWLINE);
         end
      end

      // Store full: fill with an open sentence, later bytes are all dropped
      while (sb.fill < BUFFER_BYTES - 1 || sb.holds_newline())
         send_byte((sb.fill == 0) ? CH_DOLLAR : 8'("N"));
      send_byte(CH_NEWLINE);
      send_byte(CH_DOLLAR);
      send_byte(8'h55);
      req_valid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
